FILE: hdl/chws_pkg.sv
`default_nettype none
package chws_pkg;

    localparam int DEF_BUCKETS  = 26;
    localparam int DEF_MAX_LEN  = 45;
    localparam int DEF_CAPACITY = 1024;

    localparam int CNT_W = 11;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic       last_char;
    } cmd_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] word_total;
        logic [1:0]       status;
    } rsp_t;

    // control from the sequencer into the hash accumulator
    typedef struct packed {
        logic step;
        logic close;
        logic clear;
    } chws_hctl_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/chained_hash_word_set.sv
`default_nettype none
// Channel      Handshake                      Payload
// command      start in, busy out             cmd    (chws_pkg::cmd_t)
// result       result_valid out, one cycle    result (chws_pkg::rsp_t)
//
// Words stream one byte per cycle while busy is low. Closing an insert writes the
// entry in S_HEAD; a rejected word (too long, full) gives its result the cycle
// after and stays ready. A lookup reads the bucket head, then for each chain entry
// visited reads the entry data from memory (S_NODE, S_META) and, when lengths
// match, compares the characters one by one over the char memory port (S_CMP).
// Clear and reset run a sweep over the head memory with busy high.
// The receiver cannot stall: result_valid is a single-cycle strobe.
module chained_hash_word_set #(
    parameter int BUCKETS  = chws_pkg::DEF_BUCKETS,
    parameter int MAX_LEN  = chws_pkg::DEF_MAX_LEN,
    parameter int CAPACITY = chws_pkg::DEF_CAPACITY
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire chws_pkg::cmd_t cmd,
    output logic                result_valid,
    output chws_pkg::rsp_t      result
);
    import chws_pkg::*;

    localparam int LW  = $clog2(MAX_LEN + 2);
    localparam int SW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EW  = $clog2(CAPACITY + 1);
    localparam int MW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int AW  = (CAPACITY * MAX_LEN > 1) ? $clog2(CAPACITY * MAX_LEN) : 1;
    localparam int AW1 = $clog2(CAPACITY * MAX_LEN + 1);
    localparam int CHARS = CAPACITY * MAX_LEN;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HEAD,
        S_NODE,
        S_META,
        S_CMP
    } state_t;

    // memories
    logic [7:0]    char_mem [CHARS];
    logic [7:0]    pend_mem [MAX_LEN];
    logic [LW-1:0] len_mem  [CAPACITY];
    logic [EW-1:0] next_mem [CAPACITY];
    logic [EW-1:0] head_mem [BUCKETS];

    logic [7:0]    char_q, pend_q;
    logic [LW-1:0] mlen_q;
    logic [EW-1:0] mnext_q, head_q;

    // control registers
    state_t        state_reg, state_next;
    logic [EW-1:0] ent_reg, ent_next;
    logic [AW1-1:0] wbase_reg, wbase_next;
    logic [SW-1:0] bkt_reg, bkt_next;
    logic [SW-1:0] sweep_reg, sweep_next;
    logic          clr_reg, clr_next;
    logic          ins_reg, ins_next;
    logic [LW-1:0] wlen_reg, wlen_next;
    logic [EW-1:0] cur_reg, cur_next;
    logic [EW-1:0] nxt_reg, nxt_next;
    logic [AW-1:0] base_reg, base_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic          rv_reg, rv_next;
    rsp_t          rsp_reg, rsp_next;

    // memory ports
    logic          head_we;
    logic [SW-1:0] head_waddr, head_raddr;
    logic [EW-1:0] head_wdata;
    logic          meta_we;
    logic          char_we, pend_we;

    // hash accumulator
    chws_hctl_t    hctl;
    logic [LW-1:0] hlen, hlen_upd;
    logic [SW-1:0] hsum_upd;
    logic          accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && (state_reg == S_IDLE);

    assign hctl.step  = accept && (cmd.mode == MODE_INSERT || cmd.mode == MODE_LOOKUP);
    assign hctl.close = cmd.last_char;
    assign hctl.clear = accept && (cmd.mode == MODE_CLEAR);

    chws_hash #(
        .BUCKETS (BUCKETS),
        .MAX_LEN (MAX_LEN)
    ) u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (hctl),
        .char_code (cmd.char_code),
        .len       (hlen),
        .len_upd   (hlen_upd),
        .sum_upd   (hsum_upd)
    );

    // each byte lands in the pending buffer and also in the next free entry,
    // so an insert needs no copy
    assign pend_we = hctl.step && (hlen < LW'(MAX_LEN));
    assign char_we = pend_we && (ent_reg < EW'(CAPACITY));

    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        wbase_next = wbase_reg;
        bkt_next   = bkt_reg;
        sweep_next = sweep_reg;
        clr_next   = clr_reg;
        ins_next   = ins_reg;
        wlen_next  = wlen_reg;
        cur_next   = cur_reg;
        nxt_next   = nxt_reg;
        base_next  = base_reg;
        idx_next   = idx_reg;
        rv_next    = 1'b0;
        rsp_next   = rsp_reg;
        head_we    = 1'b0;
        head_waddr = bkt_reg;
        head_wdata = ent_reg;
        head_raddr = hsum_upd;
        meta_we    = 1'b0;

        case (state_reg)
            S_SWEEP:
            begin
                head_we    = 1'b1;
                head_waddr = sweep_reg;
                head_wdata = EW'(CAPACITY);
                sweep_next = sweep_reg + SW'(1);
                if (sweep_reg == SW'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                    if (clr_reg)
                    begin
                        rv_next  = 1'b1;
                        rsp_next = '{found: 1'b0, word_total: '0, status: ST_OK};
                    end
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.mode)
                        MODE_INSERT, MODE_LOOKUP:
                        begin
                            if (cmd.last_char)
                            begin
                                if (hlen_upd > LW'(MAX_LEN))
                                begin
                                    rv_next  = 1'b1;
                                    rsp_next = '{found: 1'b0, word_total: CNT_W'(ent_reg),
                                                 status: ST_TOO_LONG};
                                end
                                else if (cmd.mode == MODE_INSERT &&
                                         ent_reg >= EW'(CAPACITY))
                                begin
                                    rv_next  = 1'b1;
                                    rsp_next = '{found: 1'b0, word_total: CNT_W'(ent_reg),
                                                 status: ST_FULL};
                                end
                                else
                                begin
                                    state_next = S_HEAD;
                                    wlen_next  = hlen_upd;
                                    bkt_next   = hsum_upd;
                                    ins_next   = (cmd.mode == MODE_INSERT);
                                end
                            end
                        end
                        MODE_CLEAR:
                        begin
                            ent_next   = '0;
                            wbase_next = '0;
                            sweep_next = '0;
                            clr_next   = 1'b1;
                            state_next = S_SWEEP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_HEAD:
            begin
                if (ins_reg)
                begin
                    // push the new entry onto the front of its chain
                    meta_we    = 1'b1;
                    head_we    = 1'b1;
                    ent_next   = ent_reg + EW'(1);
                    wbase_next = wbase_reg + AW1'(MAX_LEN);
                    rv_next    = 1'b1;
                    rsp_next   = '{found: 1'b0, word_total: CNT_W'(ent_reg + EW'(1)),
                                   status: ST_OK};
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next   = head_q;
                    state_next = S_NODE;
                end
            end
            S_NODE:
            begin
                if (cur_reg >= ent_reg)
                begin
                    rv_next    = 1'b1;
                    rsp_next   = '{found: 1'b0, word_total: CNT_W'(ent_reg), status: ST_OK};
                    state_next = S_IDLE;
                end
                else
                begin
                    base_next  = AW'(cur_reg) * AW'(MAX_LEN);
                    state_next = S_META;
                end
            end
            S_META:
            begin
                if (mlen_q != wlen_reg)
                begin
                    cur_next   = mnext_q;
                    state_next = S_NODE;
                end
                else
                begin
                    idx_next   = '0;
                    nxt_next   = mnext_q;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (fold_case(char_q) != fold_case(pend_q))
                begin
                    cur_next   = nxt_reg;
                    state_next = S_NODE;
                end
                else if (LW'(idx_reg) + LW'(1) == wlen_reg)
                begin
                    rv_next    = 1'b1;
                    rsp_next   = '{found: 1'b1, word_total: CNT_W'(ent_reg), status: ST_OK};
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + PW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            ent_reg   <= '0;
            wbase_reg <= '0;
            sweep_reg <= '0;
            clr_reg   <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ent_reg   <= ent_next;
            wbase_reg <= wbase_next;
            sweep_reg <= sweep_next;
            clr_reg   <= clr_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bkt_reg  <= bkt_next;
        ins_reg  <= ins_next;
        wlen_reg <= wlen_next;
        cur_reg  <= cur_next;
        nxt_reg  <= nxt_next;
        base_reg <= base_next;
        idx_reg  <= idx_next;
        rsp_reg  <= rsp_next;
    end

    // character store and pending buffer
    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            char_mem[AW'(wbase_reg + AW1'(hlen))] <= cmd.char_code;
        end
        char_q <= char_mem[base_reg + AW'(idx_next)];
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[hlen[PW-1:0]] <= cmd.char_code;
        end
        pend_q <= pend_mem[idx_next];
    end

    // per-entry length and chain link
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            len_mem[ent_reg[MW-1:0]]  <= wlen_reg;
            next_mem[ent_reg[MW-1:0]] <= head_q;
        end
        mlen_q  <= len_mem[cur_reg[MW-1:0]];
        mnext_q <= next_mem[cur_reg[MW-1:0]];
    end

    // bucket heads
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_q <= head_mem[head_raddr];
    end

    assign result_valid = rv_reg;
    assign result       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ent_reg <= EW'(CAPACITY))
        else $error("entry count beyond capacity");
    a_wbase: assert property (@(posedge clk) disable iff (!rst_n)
        wbase_reg == AW1'(ent_reg) * AW1'(MAX_LEN))
        else $error("write base out of step with entry count");
    a_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HEAD && ins_reg) |=> ent_reg == $past(ent_reg) + EW'(1))
        else $error("insert did not advance entry count");
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.found) |-> result.status == ST_OK)
        else $error("found with error status");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_META || state_reg == S_CMP) |-> cur_reg < ent_reg)
        else $error("walk visiting unallocated entry");
`endif

endmodule
`default_nettype wire

FILE: hdl/chws_hash.sv
`default_nettype none
module chws_hash #(
    parameter int BUCKETS = chws_pkg::DEF_BUCKETS,
    parameter int MAX_LEN = chws_pkg::DEF_MAX_LEN,
    localparam int LW     = $clog2(MAX_LEN + 2),
    localparam int SW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire chws_pkg::chws_hctl_t   ctl,
    input  wire logic [7:0]             char_code,
    output logic [LW-1:0]               len,
    output logic [LW-1:0]               len_upd,
    output logic [SW-1:0]               sum_upd
);
    import chws_pkg::*;

    localparam int RAW_W = $clog2(BUCKETS + 256);

    logic [LW-1:0] len_reg, len_next;
    logic [SW-1:0] sum_reg, sum_next;

    // running sum mod BUCKETS: restoring subtract of shifted constant multiples
    always_comb
    begin
        logic [RAW_W-1:0] raw;
        raw = RAW_W'(sum_reg) + RAW_W'(fold_case(char_code));
        for (int k = RAW_W - 1; k >= 0; k--)
        begin
            if ((BUCKETS << k) < (BUCKETS + 256))
            begin
                if (raw >= RAW_W'(BUCKETS << k))
                begin
                    raw = raw - RAW_W'(BUCKETS << k);
                end
            end
        end
        if (len_reg < LW'(MAX_LEN))
        begin
            len_upd = len_reg + LW'(1);
            sum_upd = SW'(raw);
        end
        else
        begin
            len_upd = LW'(MAX_LEN + 1);
            sum_upd = sum_reg;
        end
    end

    always_comb
    begin
        len_next = len_reg;
        sum_next = sum_reg;
        if (ctl.clear || (ctl.step && ctl.close))
        begin
            len_next = '0;
            sum_next = '0;
        end
        else if (ctl.step)
        begin
            len_next = len_upd;
            sum_next = sum_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            sum_reg <= sum_next;
        end
    end

    assign len = len_reg;

`ifndef NO_ASSERTIONS
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg < SW'(BUCKETS) || BUCKETS == (1 << SW))
        else $error("bucket sum out of range");
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_LEN + 1))
        else $error("pending length out of range");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> len_reg == '0 && sum_reg == '0)
        else $error("clear did not empty pending word");
`endif

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

// Testbench for chained_hash_word_set.
// Command transactions are queued by the stimulus process, and the driver
// plays them out one after another. The driver updates a behavioral word set
// at every accepted transaction and pushes the response it predicts. The
// monitor compares each result strobe with the oldest predicted response.
module testbench;
    import chws_pkg::*;

    localparam int NBKT    = DEF_BUCKETS;
    localparam int MAXL    = DEF_MAX_LEN;
    localparam int CAP     = DEF_CAPACITY;
    localparam int NULLPTR = CAP;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        cmd_t c;
        bit   hold;   // wait for an empty scoreboard before presenting
    } queued_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd = '0;
    logic busy;
    logic result_valid;
    rsp_t result;

    chained_hash_word_set uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .result_valid(result_valid),
        .result(result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- behavioral word set ----------------
    logic [7:0] word_bytes [CAP][MAXL];
    int         word_len   [CAP];
    int         chain_link [CAP];
    int         bucket_top [NBKT];
    int         words_held;
    logic [7:0] partial_word [MAXL];
    int         partial_len;
    int         partial_sum;

    queued_cmd_t pending_cmds[$];
    rsp_t        expected_rsps[$];
    int          mismatches = 0;
    int          gap_left = 0;
    longint      cycle_count = 0;

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic void empty_word_set();
        for (int b = 0; b < NBKT; b++)
        begin
            bucket_top[b] = NULLPTR;
        end
        words_held = 0;
        partial_len = 0;
        partial_sum = 0;
    endfunction

    function automatic bit same_word(input int e);
        if (word_len[e] != partial_len)
        begin
            return 1'b0;
        end
        for (int i = 0; i < partial_len; i++)
        begin
            if (lower_byte(word_bytes[e][i]) != lower_byte(partial_word[i]))
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Applies one accepted transaction; queues a response when one is due.
    function automatic void apply_transaction(input cmd_t c);
        rsp_t r;
        int   b;
        int   e;
        int   steps;
        r = '0;
        if (c.mode == MODE_NONE)
        begin
            return;
        end
        if (c.mode == MODE_CLEAR)
        begin
            empty_word_set();
            r.status = ST_OK;
            expected_rsps.push_back(r);
            return;
        end
        if (partial_len < MAXL)
        begin
            partial_word[partial_len] = c.char_code;
            partial_len++;
            partial_sum = (partial_sum + lower_byte(c.char_code)) % NBKT;
        end
        else
        begin
            partial_len = MAXL + 1;   // sticky overflow mark
        end
        if (!c.last_char)
        begin
            return;
        end
        r.status = ST_OK;
        b = partial_sum;
        if (partial_len > MAXL)
        begin
            r.status = ST_TOO_LONG;
        end
        else if (c.mode == MODE_INSERT)
        begin
            if (words_held >= CAP)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                e = words_held;
                for (int i = 0; i < partial_len; i++)
                begin
                    word_bytes[e][i] = partial_word[i];
                end
                word_len[e] = partial_len;
                chain_link[e] = bucket_top[b];
                bucket_top[b] = e;
                words_held++;
            end
        end
        else
        begin
            e = bucket_top[b];
            steps = 0;
            while (e < words_held && steps < CAP)
            begin
                if (same_word(e))
                begin
                    r.found = 1'b1;
                    break;
                end
                e = chain_link[e];
                steps++;
            end
        end
        r.word_total = words_held[CNT_W-1:0];
        expected_rsps.push_back(r);
        partial_len = 0;
        partial_sum = 0;
    endfunction

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 70)
        begin
            return 0;
        end
        if (p < 95)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        queued_cmd_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_transaction(cmd);
            end
            if (start && busy)
            begin
                // transaction still waiting; hold it steady
            end
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].hold && expected_rsps.size() != 0))
            begin
                nxt = pending_cmds.pop_front();
                cmd <= nxt.c;
                start <= 1'b1;
                gap_left <= pick_gap();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    task automatic report(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && result_valid)
        begin
            if (expected_rsps.size() == 0)
            begin
                report("unexpected result, word_total", result.word_total, -1);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (result.found !== want.found)
                    report("found", result.found, want.found);
                if (result.word_total !== want.word_total)
                    report("word_total", result.word_total, want.word_total);
                if (result.status !== want.status)
                    report("status", result.status, want.status);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    logic [7:0] recent_words [16][MAXL];
    int         recent_len [16];
    int         recent_n = 0;
    int         queued_total = 0;

    task automatic queue_cmd(input logic [1:0] m, input logic [7:0] ch, input logic lst,
                             input bit hold);
        queued_cmd_t q;
        q.c.mode = m;
        q.c.char_code = ch;
        q.c.last_char = lst;
        q.hold = hold;
        pending_cmds.push_back(q);
        queued_total++;
    endtask

    function automatic logic [7:0] random_char();
        // Letters dominate so case folding gets exercised.
        if ($urandom_range(9) < 7)
            return $urandom_range(1) ? 8'(8'h41 + $urandom_range(25))
                                     : 8'(8'h61 + $urandom_range(25));
        return 8'($urandom_range(255));
    endfunction

    // Queues a whole word; reuses a recent word (case scrambled) when asked.
    task automatic queue_word(input logic [1:0] m, input int n, input bit reuse);
        logic [7:0] w [MAXL + 8];
        int slot;
        int len;
        len = n;
        if (reuse && recent_n > 0)
        begin
            slot = $urandom_range(((recent_n < 16) ? recent_n : 16) - 1);
            len = recent_len[slot];
            for (int i = 0; i < len; i++)
            begin
                w[i] = recent_words[slot][i];
                if (lower_byte(w[i]) >= 8'h61 && lower_byte(w[i]) <= 8'h7A &&
                    $urandom_range(1))
                    w[i] = w[i] ^ 8'h20;
            end
        end
        else
        begin
            for (int i = 0; i < len; i++)
                w[i] = random_char();
            if (m == MODE_INSERT && len <= MAXL)
            begin
                slot = recent_n % 16;
                for (int i = 0; i < len; i++)
                    recent_words[slot][i] = w[i];
                recent_len[slot] = len;
                recent_n++;
            end
        end
        for (int i = 0; i < len; i++)
            queue_cmd(m, w[i], i == len - 1, 1'b0);
    endtask

    initial
    begin
        int pick;
        int n;
        logic [1:0] m;
        empty_word_set();

        // directed: extremes, case folding, mixed modes, ignored mode, clears
        queue_cmd(MODE_INSERT, 8'h41, 1'b0, 1'b0);      // "Ab"
        queue_cmd(MODE_INSERT, 8'h62, 1'b1, 1'b0);
        queue_cmd(MODE_LOOKUP, 8'h61, 1'b0, 1'b0);      // "aB" matches
        queue_cmd(MODE_LOOKUP, 8'h42, 1'b1, 1'b0);
        queue_cmd(MODE_LOOKUP, 8'h61, 1'b0, 1'b0);      // "ax" misses
        queue_cmd(MODE_LOOKUP, 8'h78, 1'b1, 1'b0);
        queue_cmd(MODE_INSERT, 8'h00, 1'b1, 1'b0);      // byte zero is a word
        queue_cmd(MODE_INSERT, 8'hFF, 1'b1, 1'b0);
        queue_cmd(MODE_LOOKUP, 8'h00, 1'b1, 1'b0);
        queue_cmd(MODE_LOOKUP, 8'h5B, 1'b1, 1'b0);      // just past 'Z', no fold
        queue_cmd(MODE_NONE, 8'hFF, 1'b1, 1'b0);        // ignored
        queue_cmd(MODE_LOOKUP, 8'h61, 1'b0, 1'b0);      // mode of closing byte wins
        queue_cmd(MODE_INSERT, 8'h7A, 1'b1, 1'b0);
        queue_cmd(MODE_INSERT, 8'h41, 1'b0, 1'b0);
        queue_cmd(MODE_LOOKUP, 8'h5A, 1'b1, 1'b0);
        queue_cmd(MODE_INSERT, 8'h33, 1'b0, 1'b0);      // partial word, then clear
        queue_cmd(MODE_CLEAR, 8'hFF, 1'b1, 1'b1);       // sender drains first
        queue_cmd(MODE_LOOKUP, 8'h61, 1'b0, 1'b0);
        queue_cmd(MODE_LOOKUP, 8'h62, 1'b1, 1'b0);
        queue_cmd(MODE_CLEAR, 8'h00, 1'b0, 1'b0);

        // random: mostly well-formed words, some noise and broken sequences
        while (queued_total < 50)
        begin
            pick = $urandom_range(99);
            m = $urandom_range(1) ? MODE_INSERT : MODE_LOOKUP;
            n = ($urandom_range(9) < 8) ? $urandom_range(8, 1) : $urandom_range(MAXL, 9);
            if (pick < 45)
                queue_word(m, n, 1'b0);
            else if (pick < 85)
                queue_word(MODE_LOOKUP, n, 1'b1);
            else if (pick < 89)
                queue_word(m, $urandom_range(MAXL + 6, MAXL + 1), 1'b0);
            else if (pick < 93)
                queue_cmd(MODE_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
            else if (pick < 97)
                queue_cmd($urandom_range(1) ? MODE_INSERT : MODE_LOOKUP,
                          random_char(), 1'b0, 1'b0);  // stray byte joins next word
            else if (pick < 99)
                queue_cmd(MODE_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'b0);
            else
                queue_cmd(MODE_CLEAR, 8'h00, 1'b0, 1'b1);
        end

        // fill to capacity with one-byte words, then overflow it
        queue_cmd(MODE_CLEAR, 8'h00, 1'b1, 1'b0);
        for (int i = 0; i < CAP + 2; i++)
            queue_cmd(MODE_INSERT, 8'($urandom_range(255)), 1'b1, 1'b0);
        queue_word(MODE_LOOKUP, 1, 1'b0);
        queue_word(MODE_LOOKUP, 3, 1'b0);
        queue_word(MODE_INSERT, 4, 1'b0);
        queue_cmd(MODE_CLEAR, 8'hFF, 1'b1, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_cmds.size() == 0 && !start);
        wait (expected_rsps.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
